// ===== rtl/core/lsr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package lsr_pkg;
	localparam int PHI_W = 32;
	localparam int SPC_W = 31;
	localparam int TSF_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int SIGN_FRAC = 30;
	localparam int SMAG_W = 31;
	localparam int SLOPE_W = 31;
	localparam int RAD_W = 64;
	localparam int ROOT_W = 32;
	localparam logic [TSF_W-1:0] TSF_RESET = 16'h8000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SPACING_X = 2'd0,
		CFG_SPACING_Y = 2'd1,
		CFG_SPACING_Z = 2'd2,
		CFG_TIMESTEP  = 2'd3
	} cfg_idx_t;
endpackage
`default_nettype wire

// ===== rtl/core/lsr_delay.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lsr_delay #(
	parameter int W = 1,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);
	logic [W-1:0] dly_s [N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) begin
				dly_s[i] <= '0;
			end
		end else if (en) begin
			dly_s[0] <= d;
			for (int i = 1; i < N; i++) begin
				dly_s[i] <= dly_s[i-1];
			end
		end
	end

	assign q = dly_s[N-1];
endmodule
`default_nettype wire

// ===== rtl/core/lsr_isqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lsr_isqrt #(
	parameter int IN_W = 64
) (
	input  logic              clk,
	input  logic              en,
	input  logic [IN_W-1:0]   rad,
	output logic [IN_W/2-1:0] root
);
	localparam int OW = IN_W / 2;
	localparam int REM_W = OW + 2;
	localparam int CUR_W = OW + 4;

	logic [IN_W-1:0]  rad_s  [OW];
	logic [REM_W-1:0] rem_s  [OW];
	logic [OW-1:0]    root_s [OW];

	genvar k;
	for (k = 0; k < OW; k++) begin : g_step
		logic [IN_W-1:0]  rad_in;
		logic [REM_W-1:0] rem_in;
		logic [OW-1:0]    root_in;
		logic [CUR_W-1:0] cur;
		logic [CUR_W-1:0] trial;
		logic [CUR_W-1:0] diff;
		logic             ge;

		if (k == 0) begin : g_first
			assign rad_in = rad;
			assign rem_in = '0;
			assign root_in = '0;
		end else begin : g_next
			assign rad_in = rad_s[k-1];
			assign rem_in = rem_s[k-1];
			assign root_in = root_s[k-1];
		end

		assign cur = {rem_in, rad_in[IN_W-1 -: 2]};
		assign trial = {2'b00, root_in, 2'b01};
		assign ge = cur >= trial;
		assign diff = cur - trial;

		always_ff @(posedge clk) begin
			if (en) begin
				root_s[k] <= {root_in[OW-2:0], ge};
			end
		end

		if (k < OW - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rad_s[k] <= rad_in << 2;
					rem_s[k] <= ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
				end
			end
		end
	end

	assign root = root_s[OW-1];
endmodule
`default_nettype wire

// ===== rtl/core/lsr_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lsr_div #(
	parameter int QW = 31,
	parameter int DW = 31
) (
	input  logic            clk,
	input  logic            en,
	input  logic [QW+DW-1:0] num,
	input  logic [DW-1:0]   den,
	output logic [QW-1:0]   quo
);
	logic [QW-1:0] lo_s  [QW];
	logic [DW-1:0] rem_s [QW];
	logic [DW-1:0] den_s [QW];

	genvar k;
	for (k = 0; k < QW; k++) begin : g_step
		logic [QW-1:0] lo_in;
		logic [DW-1:0] rem_in;
		logic [DW-1:0] den_in;
		logic [DW:0]   cur;
		logic [DW:0]   diff;
		logic          ge;

		if (k == 0) begin : g_first
			assign lo_in = num[QW-1:0];
			assign rem_in = num[QW+DW-1:QW];
			assign den_in = den;
		end else begin : g_next
			assign lo_in = lo_s[k-1];
			assign rem_in = rem_s[k-1];
			assign den_in = den_s[k-1];
		end

		assign cur = {rem_in, lo_in[QW-1]};
		assign ge = cur >= {1'b0, den_in};
		assign diff = cur - {1'b0, den_in};

		always_ff @(posedge clk) begin
			if (en) begin
				lo_s[k] <= {lo_in[QW-2:0], ge};
			end
		end

		if (k < QW - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= ge ? diff[DW-1:0] : cur[DW-1:0];
					den_s[k] <= den_in;
				end
			end
		end
	end

	assign quo = lo_s[QW-1];
endmodule
`default_nettype wire

// ===== rtl/core/level_set_reinit_cell_update_top.sv =====
// Throughput: one item per cycle; the whole pipeline holds only while the
// output register and its skid register are both full.
// Reset clears all valid bits and the skid state, and loads the spacing
// registers with 1.0 and the timestep factor with 0.5.
`timescale 1ns / 1ps
`default_nettype none
module level_set_reinit_cell_update_top #(
	parameter int FRAC_BITS = 20
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [lsr_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [lsr_pkg::SPC_W-1:0]            cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [lsr_pkg::PHI_W-1:0]     phi_centre,
	input  logic signed [lsr_pkg::PHI_W-1:0]     phi_x_minus,
	input  logic signed [lsr_pkg::PHI_W-1:0]     phi_x_plus,
	input  logic signed [lsr_pkg::PHI_W-1:0]     phi_y_minus,
	input  logic signed [lsr_pkg::PHI_W-1:0]     phi_y_plus,
	input  logic signed [lsr_pkg::PHI_W-1:0]     phi_z_minus,
	input  logic signed [lsr_pkg::PHI_W-1:0]     phi_z_plus,
	input  logic signed [lsr_pkg::PHI_W-1:0]     phi_initial,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [lsr_pkg::PHI_W-1:0]     phi_next
);
	import lsr_pkg::*;

	localparam int DIV_LAT = SLOPE_W;
	localparam int ISQ_LAT = ROOT_W;
	localparam int NUM_W = SLOPE_W + SPC_W;
	localparam int SNUM_W = SMAG_W + ROOT_W;
	localparam int SQ_W = 2 * SLOPE_W;
	localparam int GM_W = ROOT_W + 2;
	localparam int RES_W = 66;
	localparam int GRAD_STAGE = 2 + DIV_LAT + 3 + ISQ_LAT;
	localparam int SIGN_STAGE = 3 + ISQ_LAT + DIV_LAT;
	localparam int M0_DLY = 3 + ISQ_LAT - 1;
	localparam int SIDE_DLY = GRAD_STAGE - 1;
	localparam int SIGN_PAD = GRAD_STAGE - SIGN_STAGE;
	localparam int SIDE_W = PHI_W + 3;
	localparam logic [SPC_W-1:0] SPC_RESET = SPC_W'(1) << FRAC_BITS;
	localparam logic [GM_W-1:0] ONE = GM_W'(1) << FRAC_BITS;
	localparam logic signed [RES_W-1:0] RES_MAX = 66'sh7FFFFFFF;
	localparam logic signed [RES_W-1:0] RES_MIN = -66'sh80000000;

	logic [SPC_W-1:0] spc_x_q, spc_y_q, spc_z_q;
	logic [TSF_W-1:0] tsf_q;
	logic [SPC_W-1:0] den_x, den_y, den_z, h_min;
	logic [SPC_W-1:0] den_ln [6];
	logic [TSF_W+SPC_W-1:0] tsf_h;
	logic [SPC_W-1:0] dtau_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spc_x_q <= SPC_RESET;
			spc_y_q <= SPC_RESET;
			spc_z_q <= SPC_RESET;
			tsf_q <= TSF_RESET;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_SPACING_X: spc_x_q <= cfg_data;
				CFG_SPACING_Y: spc_y_q <= cfg_data;
				CFG_SPACING_Z: spc_z_q <= cfg_data;
				CFG_TIMESTEP: tsf_q <= cfg_data[TSF_W-1:0];
				default: ;
			endcase
		end
	end

	// A zero spacing acts as the smallest representable spacing.
	assign den_x = (spc_x_q == '0) ? SPC_W'(1) : spc_x_q;
	assign den_y = (spc_y_q == '0) ? SPC_W'(1) : spc_y_q;
	assign den_z = (spc_z_q == '0) ? SPC_W'(1) : spc_z_q;

	always_comb begin
		h_min = den_x;
		if (den_y < h_min) h_min = den_y;
		if (den_z < h_min) h_min = den_z;
	end

	assign den_ln[0] = den_x;
	assign den_ln[1] = den_x;
	assign den_ln[2] = den_y;
	assign den_ln[3] = den_y;
	assign den_ln[4] = den_z;
	assign den_ln[5] = den_z;

	assign tsf_h = (TSF_W+SPC_W)'(tsf_q) * (TSF_W+SPC_W)'(h_min);

	always_ff @(posedge clk) begin
		dtau_q <= tsf_h[TSF_W+SPC_W-1:TSF_W];
	end

	logic en;
	logic skid_v_q, out_v_q;
	assign en = !skid_v_q;
	assign in_stall = skid_v_q;

	// Stage 1: differences, magnitude of the initial phi and the freeze test.
	logic signed [PHI_W:0] dif_in [6];
	logic [PHI_W-1:0] m0_in;
	logic [PHI_W+1:0] thr;
	logic frz_in;

	assign dif_in[0] = {phi_centre[PHI_W-1], phi_centre} - {phi_x_minus[PHI_W-1], phi_x_minus};
	assign dif_in[1] = {phi_x_plus[PHI_W-1], phi_x_plus} - {phi_centre[PHI_W-1], phi_centre};
	assign dif_in[2] = {phi_centre[PHI_W-1], phi_centre} - {phi_y_minus[PHI_W-1], phi_y_minus};
	assign dif_in[3] = {phi_y_plus[PHI_W-1], phi_y_plus} - {phi_centre[PHI_W-1], phi_centre};
	assign dif_in[4] = {phi_centre[PHI_W-1], phi_centre} - {phi_z_minus[PHI_W-1], phi_z_minus};
	assign dif_in[5] = {phi_z_plus[PHI_W-1], phi_z_plus} - {phi_centre[PHI_W-1], phi_centre};
	assign m0_in = phi_initial[PHI_W-1] ? (~phi_initial + PHI_W'(1)) : phi_initial;
	assign thr = (PHI_W+2)'(h_min) + (PHI_W+2)'({h_min, 1'b0});
	assign frz_in = {m0_in, 2'b00} < thr;

	logic v_s1, pos_s1, neg_s1, frz_s1;
	logic signed [PHI_W-1:0] pc_s1;
	logic signed [PHI_W:0] diff_s1 [6];
	logic [PHI_W-1:0] m0_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pc_s1 <= phi_centre;
			for (int i = 0; i < 6; i++) begin
				diff_s1[i] <= dif_in[i];
			end
			m0_s1 <= m0_in;
			pos_s1 <= !phi_initial[PHI_W-1] && (phi_initial != '0);
			neg_s1 <= phi_initial[PHI_W-1];
			frz_s1 <= frz_in;
		end
	end

	// Smoothed sign path.
	logic [RAD_W-1:0] m0sq_s2, hsq_s2, sumsq_s3;
	logic [ROOT_W-1:0] root_s35;
	logic [PHI_W-1:0] m0_s35;
	logic [SMAG_W-1:0] smag_s66, smag_s68;

	always_ff @(posedge clk) begin
		if (en) begin
			m0sq_s2 <= RAD_W'(m0_s1) * RAD_W'(m0_s1);
			hsq_s2 <= RAD_W'(h_min) * RAD_W'(h_min);
			sumsq_s3 <= m0sq_s2 + hsq_s2;
		end
	end

	lsr_isqrt #(.IN_W(RAD_W)) u_root (
		.clk(clk), .en(en), .rad(sumsq_s3), .root(root_s35)
	);

	lsr_delay #(.W(PHI_W), .N(M0_DLY)) u_m0_dly (
		.clk(clk), .arst_n(arst_n), .en(en), .d(m0_s1), .q(m0_s35)
	);

	lsr_div #(.QW(SMAG_W), .DW(ROOT_W)) u_sign (
		.clk(clk), .en(en), .num(SNUM_W'(m0_s35) << SIGN_FRAC), .den(root_s35),
		.quo(smag_s66)
	);

	lsr_delay #(.W(SMAG_W), .N(SIGN_PAD)) u_sign_dly (
		.clk(clk), .arst_n(arst_n), .en(en), .d(smag_s66), .q(smag_s68)
	);

	// Upwind gradient path.
	logic [NUM_W-1:0] num_s2 [6];
	logic sat_s2 [6];
	logic use_s2 [6];
	logic [11:0] flag_s2, flag_s33;
	logic [SLOPE_W-1:0] quo_s33 [6];

	genvar gi;
	for (gi = 0; gi < 6; gi++) begin : g_lane
		localparam bit IS_MINUS = (gi % 2) == 0;
		logic [PHI_W-1:0] mag;
		logic [63:0] nfull, lim;
		logic sat, pdir, ndir;

		assign mag = diff_s1[gi][PHI_W] ? PHI_W'(-diff_s1[gi]) : diff_s1[gi][PHI_W-1:0];
		assign nfull = 64'(mag) << FRAC_BITS;
		assign lim = 64'(den_ln[gi]) << SLOPE_W;
		assign sat = nfull >= lim;
		assign pdir = !diff_s1[gi][PHI_W] && (diff_s1[gi] != '0);
		assign ndir = diff_s1[gi][PHI_W];

		always_ff @(posedge clk) begin
			if (en) begin
				num_s2[gi] <= sat ? '0 : nfull[NUM_W-1:0];
				sat_s2[gi] <= sat;
				if (IS_MINUS) begin
					use_s2[gi] <= pos_s1 ? pdir : ndir;
				end else begin
					use_s2[gi] <= pos_s1 ? ndir : pdir;
				end
			end
		end

		assign flag_s2[6+gi] = sat_s2[gi];
		assign flag_s2[gi] = use_s2[gi];

		lsr_div #(.QW(SLOPE_W), .DW(SPC_W)) u_slope (
			.clk(clk), .en(en), .num(num_s2[gi]), .den(den_ln[gi]), .quo(quo_s33[gi])
		);
	end

	lsr_delay #(.W(12), .N(DIV_LAT)) u_flag_dly (
		.clk(clk), .arst_n(arst_n), .en(en), .d(flag_s2), .q(flag_s33)
	);

	logic [SLOPE_W-1:0] amax_s34 [3];
	logic [SQ_W-1:0] sq_s35 [3];
	logic [RAD_W-1:0] gsum_s36;
	logic [ROOT_W-1:0] grad_s68;

	genvar ga;
	for (ga = 0; ga < 3; ga++) begin : g_axis
		logic [SLOPE_W-1:0] qa, qb, ma, mb;

		assign qa = flag_s33[6+2*ga] ? '1 : quo_s33[2*ga];
		assign qb = flag_s33[7+2*ga] ? '1 : quo_s33[2*ga+1];
		assign ma = flag_s33[2*ga] ? qa : '0;
		assign mb = flag_s33[2*ga+1] ? qb : '0;

		always_ff @(posedge clk) begin
			if (en) begin
				amax_s34[ga] <= (ma > mb) ? ma : mb;
				sq_s35[ga] <= SQ_W'(amax_s34[ga]) * SQ_W'(amax_s34[ga]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			gsum_s36 <= RAD_W'(sq_s35[0]) + RAD_W'(sq_s35[1]) + RAD_W'(sq_s35[2]);
		end
	end

	lsr_isqrt #(.IN_W(RAD_W)) u_grad (
		.clk(clk), .en(en), .rad(gsum_s36), .root(grad_s68)
	);

	// Item sideband: valid, freeze, sign of the initial phi, centre phi.
	logic [SIDE_W-1:0] side_s68;
	logic v_s68, frz_s68, neg_s68;
	logic signed [PHI_W-1:0] pc_s68;

	lsr_delay #(.W(SIDE_W), .N(SIDE_DLY)) u_side_dly (
		.clk(clk), .arst_n(arst_n), .en(en), .d({v_s1, frz_s1, neg_s1, pc_s1}),
		.q(side_s68)
	);
	assign {v_s68, frz_s68, neg_s68, pc_s68} = side_s68;

	// Update stages.
	logic [GM_W-1:0] gm1, gm1_neg;
	logic v_s69, v_s70, v_s71;
	logic frz_s69, frz_s70, frz_s71;
	logic neg_s69, gneg_s69, tneg_s70, tneg_s71;
	logic signed [PHI_W-1:0] pc_s69, pc_s70, pc_s71;
	logic [SMAG_W-1:0] smag_s69;
	logic [ROOT_W-1:0] gmag_s69;
	logic [SNUM_W-1:0] tprod_s70;
	logic [RAD_W-1:0] uprod_s71;

	assign gm1 = {2'b00, grad_s68} - ONE;
	assign gm1_neg = -gm1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s69 <= 1'b0;
			v_s70 <= 1'b0;
			v_s71 <= 1'b0;
		end else if (en) begin
			v_s69 <= v_s68;
			v_s70 <= v_s69;
			v_s71 <= v_s70;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			frz_s69 <= frz_s68;
			neg_s69 <= neg_s68;
			pc_s69 <= pc_s68;
			smag_s69 <= smag_s68;
			gneg_s69 <= gm1[GM_W-1];
			gmag_s69 <= gm1[GM_W-1] ? gm1_neg[ROOT_W-1:0] : gm1[ROOT_W-1:0];

			frz_s70 <= frz_s69;
			pc_s70 <= pc_s69;
			tneg_s70 <= neg_s69 ^ gneg_s69;
			tprod_s70 <= SNUM_W'(smag_s69) * SNUM_W'(gmag_s69);

			frz_s71 <= frz_s70;
			pc_s71 <= pc_s70;
			tneg_s71 <= tneg_s70;
			uprod_s71 <= RAD_W'(dtau_q) * RAD_W'(tprod_s70[SNUM_W-1:SIGN_FRAC]);
		end
	end

	logic [RAD_W-1:0] umv;
	logic signed [RES_W-1:0] pc_ext, u_ext, res;
	logic signed [PHI_W-1:0] pipe_res;

	assign umv = uprod_s71 >> FRAC_BITS;
	assign pc_ext = RES_W'(pc_s71);
	assign u_ext = {2'b00, umv};
	assign res = tneg_s71 ? (pc_ext + u_ext) : (pc_ext - u_ext);

	always_comb begin
		if (frz_s71) begin
			pipe_res = pc_s71;
		end else if (res > RES_MAX) begin
			pipe_res = RES_MAX[PHI_W-1:0];
		end else if (res < RES_MIN) begin
			pipe_res = RES_MIN[PHI_W-1:0];
		end else begin
			pipe_res = res[PHI_W-1:0];
		end
	end

	// Output register with one skid entry.
	logic take;
	logic signed [PHI_W-1:0] out_q, skid_q;

	assign take = out_v_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!skid_v_q) begin
			if (!out_v_q || take) begin
				out_v_q <= v_s71;
			end else if (v_s71) begin
				skid_v_q <= 1'b1;
			end
		end else if (take) begin
			skid_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_v_q) begin
			if (!out_v_q || take) begin
				out_q <= pipe_res;
			end else begin
				skid_q <= pipe_res;
			end
		end else if (take) begin
			out_q <= skid_q;
		end
	end

	assign out_valid = out_v_q;
	assign phi_next = out_q;
endmodule
`default_nettype wire

// ===== rtl/core/lsr_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lsr_chk (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_stall,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic signed [lsr_pkg::PHI_W-1:0] phi_next
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(phi_next))
		else $error("Stalled output item changed or vanished.");

	a_stall_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("Input stalled while the output register is empty.");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(out_valid && out_stall))
		else $error("Skid filled without a stalled output item.");

	a_stall_keep: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall && out_stall |=> in_stall)
		else $error("Skid item released while the output was stalled.");
endmodule

bind level_set_reinit_cell_update_top lsr_chk u_lsr_chk (.*);
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;
	import lsr_pkg::*;

	localparam int FRAC = 20;
	localparam int CYCLE_LIMIT = 400000;
	localparam int ITEMS_PER_PHASE = 230;
	localparam int NUM_PHASES = 8;
	localparam longint PHI_MAX = 64'sd2147483647;
	localparam longint PHI_MIN = -64'sd2147483648;

	typedef struct {
		logic signed [PHI_W-1:0] centre;
		logic signed [PHI_W-1:0] x_minus;
		logic signed [PHI_W-1:0] x_plus;
		logic signed [PHI_W-1:0] y_minus;
		logic signed [PHI_W-1:0] y_plus;
		logic signed [PHI_W-1:0] z_minus;
		logic signed [PHI_W-1:0] z_plus;
		logic signed [PHI_W-1:0] initial_phi;
	} cell_t;

	class phi_scoreboard;
		logic [63:0] spacing[3];
		logic [63:0] tsf;
		logic signed [PHI_W-1:0] pending_phi[$];
		int errors;

		function new();
			spacing[0] = 64'd1 << FRAC;
			spacing[1] = 64'd1 << FRAC;
			spacing[2] = 64'd1 << FRAC;
			tsf = 64'd32768;
			errors = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [SPC_W-1:0] v);
			case (idx)
				CFG_SPACING_X: spacing[0] = 64'(v);
				CFG_SPACING_Y: spacing[1] = 64'(v);
				CFG_SPACING_Z: spacing[2] = 64'(v);
				CFG_TIMESTEP: tsf = 64'(v[TSF_W-1:0]);
			endcase
		endfunction

		function logic [63:0] mag(longint v);
			return v < 0 ? 64'(-v) : 64'(v);
		endfunction

		function logic [63:0] root(logic [63:0] n);
			logic [63:0] res;
			logic [63:0] b;
			res = 0;
			b = 64'd1 << 62;
			while (b > n)
				b >>= 2;
			while (b != 0) begin
				if (n >= res + b) begin
					n -= res + b;
					res = (res >> 1) + b;
				end else begin
					res >>= 1;
				end
				b >>= 2;
			end
			return res;
		endfunction

		function longint slope(longint a, longint b, logic [63:0] d);
			longint diff;
			logic [63:0] m;
			diff = a - b;
			m = (mag(diff) << FRAC) / d;
			if (m > 64'h7FFFFFFF)
				m = 64'h7FFFFFFF;
			return diff < 0 ? -longint'(m) : longint'(m);
		endfunction

		function logic [63:0] axis_sq(longint dm, longint dp, bit pos);
			longint a;
			longint b;
			logic [63:0] ma;
			logic [63:0] mb;
			if (pos) begin
				a = dm > 0 ? dm : 0;
				b = dp < 0 ? dp : 0;
			end else begin
				a = dm < 0 ? dm : 0;
				b = dp > 0 ? dp : 0;
			end
			ma = mag(a) * mag(a);
			mb = mag(b) * mag(b);
			return ma > mb ? ma : mb;
		endfunction

		function logic signed [PHI_W-1:0] next_phi(cell_t c);
			logic [63:0] dx, dy, dz, h, m0, r, smag, sum, grad, dtau, tmag, u;
			longint pc, p0, gm1, res;
			bit pos, tneg;
			dx = spacing[0] == 0 ? 64'd1 : spacing[0];
			dy = spacing[1] == 0 ? 64'd1 : spacing[1];
			dz = spacing[2] == 0 ? 64'd1 : spacing[2];
			h = dx;
			if (dy < h) h = dy;
			if (dz < h) h = dz;
			pc = longint'(c.centre);
			p0 = longint'(c.initial_phi);
			m0 = mag(p0);
			if (4 * m0 < 3 * h)
				return c.centre;
			r = root(m0 * m0 + h * h);
			smag = r == 0 ? 64'd0 : (m0 << SIGN_FRAC) / r;
			pos = p0 > 0;
			sum = axis_sq(slope(pc, c.x_minus, dx), slope(c.x_plus, pc, dx), pos)
				+ axis_sq(slope(pc, c.y_minus, dy), slope(c.y_plus, pc, dy), pos)
				+ axis_sq(slope(pc, c.z_minus, dz), slope(c.z_plus, pc, dz), pos);
			grad = root(sum);
			gm1 = longint'(grad) - (64'sd1 <<< FRAC);
			dtau = (tsf * h) >> 16;
			tmag = (smag * mag(gm1)) >> SIGN_FRAC;
			tneg = (p0 < 0) != (gm1 < 0);
			u = (dtau * tmag) >> FRAC;
			res = tneg ? pc + longint'(u) : pc - longint'(u);
			if (res > PHI_MAX) res = PHI_MAX;
			if (res < PHI_MIN) res = PHI_MIN;
			return res[PHI_W-1:0];
		endfunction

		function void note_cell(cell_t c);
			pending_phi.push_back(next_phi(c));
		endfunction

		function void check_phi(logic signed [PHI_W-1:0] got);
			logic signed [PHI_W-1:0] want;
			if (pending_phi.size() == 0) begin
				$display("%0t: unexpected phi_next %0d", $time, got);
				errors++;
				return;
			end
			want = pending_phi.pop_front();
			if (got !== want) begin
				$display("%0t: phi_next expected %0d actual %0d", $time, want, got);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [SPC_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic signed [PHI_W-1:0] phi_centre, phi_x_minus, phi_x_plus, phi_y_minus;
	logic signed [PHI_W-1:0] phi_y_plus, phi_z_minus, phi_z_plus, phi_initial;
	logic out_valid;
	logic out_stall;
	logic signed [PHI_W-1:0] phi_next;

	phi_scoreboard sb;
	int send_idle_pct;
	int stall_pct;
	int cycles;

	level_set_reinit_cell_update_top #(.FRAC_BITS(FRAC)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.phi_centre(phi_centre), .phi_x_minus(phi_x_minus), .phi_x_plus(phi_x_plus),
		.phi_y_minus(phi_y_minus), .phi_y_plus(phi_y_plus),
		.phi_z_minus(phi_z_minus), .phi_z_plus(phi_z_plus),
		.phi_initial(phi_initial),
		.out_valid(out_valid), .out_stall(out_stall), .phi_next(phi_next)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	always @(negedge clk) begin
		out_stall = ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_phi(phi_next);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("level_set_reinit_cell_update_top: mismatch");
			$finish;
		end
	end

	function automatic logic signed [PHI_W-1:0] clamp32(longint v);
		if (v > PHI_MAX) v = PHI_MAX;
		if (v < PHI_MIN) v = PHI_MIN;
		return v[PHI_W-1:0];
	endfunction

	function automatic logic signed [PHI_W-1:0] rand_phi();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return clamp32(longint'($urandom_range(0, 1 << 23)) - (1 << 22));
			2: return $urandom_range(0, 1) ? PHI_MAX[PHI_W-1:0] : PHI_MIN[PHI_W-1:0];
			default: return clamp32(longint'($urandom_range(0, 1 << 27)) - (1 << 26));
		endcase
	endfunction

	function automatic logic signed [PHI_W-1:0] near(logic signed [PHI_W-1:0] c,
			logic [63:0] sp);
		longint span;
		span = sp > 64'd1 << 28 ? 64'sd1 << 28 : longint'(sp) + 1;
		case ($urandom_range(0, 5))
			0: return c;
			1: return rand_phi();
			default: return clamp32(longint'(c) + longint'($urandom_range(0, 2 * span))
				- span);
		endcase
	endfunction

	function automatic cell_t rand_cell();
		cell_t c;
		logic [63:0] h;
		longint band;
		h = sb.spacing[0];
		if (sb.spacing[1] < h) h = sb.spacing[1];
		if (sb.spacing[2] < h) h = sb.spacing[2];
		if (h == 0) h = 1;
		band = h > 64'd1 << 28 ? 64'sd1 << 30 : 4 * longint'(h);
		c.centre = rand_phi();
		c.x_minus = near(c.centre, sb.spacing[0]);
		c.x_plus = near(c.centre, sb.spacing[0]);
		c.y_minus = near(c.centre, sb.spacing[1]);
		c.y_plus = near(c.centre, sb.spacing[1]);
		c.z_minus = near(c.centre, sb.spacing[2]);
		c.z_plus = near(c.centre, sb.spacing[2]);
		case ($urandom_range(0, 2))
			0: c.initial_phi = c.centre;
			1: c.initial_phi = clamp32(longint'($urandom_range(0, 2 * band)) - band);
			default: c.initial_phi = rand_phi();
		endcase
		return c;
	endfunction

	function automatic cell_t mk(longint pc, longint xm, longint xp, longint ym,
			longint yp, longint zm, longint zp, longint p0);
		cell_t c;
		c.centre = clamp32(pc);
		c.x_minus = clamp32(xm);
		c.x_plus = clamp32(xp);
		c.y_minus = clamp32(ym);
		c.y_plus = clamp32(yp);
		c.z_minus = clamp32(zm);
		c.z_plus = clamp32(zp);
		c.initial_phi = clamp32(p0);
		return c;
	endfunction

	task automatic send_cell(cell_t c);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		phi_centre = c.centre;
		phi_x_minus = c.x_minus;
		phi_x_plus = c.x_plus;
		phi_y_minus = c.y_minus;
		phi_y_plus = c.y_plus;
		phi_z_minus = c.z_minus;
		phi_z_plus = c.z_plus;
		phi_initial = c.initial_phi;
		in_valid = 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_cell(c);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending_phi.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [SPC_W-1:0] v);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = v;
		sb.set_reg(idx, v);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_spacing(logic [SPC_W-1:0] x, logic [SPC_W-1:0] y,
			logic [SPC_W-1:0] z, logic [SPC_W-1:0] t);
		write_reg(CFG_SPACING_X, x);
		write_reg(CFG_SPACING_Y, y);
		write_reg(CFG_SPACING_Z, z);
		write_reg(CFG_TIMESTEP, t);
	endtask

	initial begin
		longint one;
		cell_t directed[$];
		sb = new();
		cycles = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		{phi_centre, phi_x_minus, phi_x_plus, phi_y_minus} = '0;
		{phi_y_plus, phi_z_minus, phi_z_plus, phi_initial} = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		one = 64'sd1 << FRAC;
		directed.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0));
		directed.push_back(mk(one, 0, 2 * one, one, one, one, one, 3 * one / 4));
		directed.push_back(mk(-one, 0, -2 * one, -one, -one, -one, -one, -3 * one / 4));
		directed.push_back(mk(5, 1, 9, 2, 8, 3, 7, 3 * one / 4 - 1));
		directed.push_back(mk(-5, 1, 9, 2, 8, 3, 7, -(3 * one / 4) + 1));
		directed.push_back(mk(PHI_MAX, PHI_MIN, PHI_MIN, PHI_MIN, PHI_MIN, PHI_MIN,
			PHI_MIN, PHI_MAX));
		directed.push_back(mk(PHI_MIN, PHI_MAX, PHI_MAX, PHI_MAX, PHI_MAX, PHI_MAX,
			PHI_MAX, PHI_MIN));
		directed.push_back(mk(PHI_MAX, PHI_MAX, PHI_MAX, PHI_MAX, PHI_MAX, PHI_MAX,
			PHI_MAX, PHI_MAX));
		directed.push_back(mk(PHI_MIN, PHI_MIN, PHI_MIN, PHI_MIN, PHI_MIN, PHI_MIN,
			PHI_MIN, PHI_MIN));
		directed.push_back(mk(PHI_MAX, 0, PHI_MIN, 0, PHI_MIN, 0, PHI_MIN, PHI_MIN));
		directed.push_back(mk(PHI_MIN, 0, PHI_MAX, 0, PHI_MAX, 0, PHI_MAX, PHI_MAX));
		directed.push_back(mk(2 * one, one, 3 * one, one, 3 * one, one, 3 * one, 2 * one));
		directed.push_back(mk(-1, -1, -1, -1, -1, -1, -1, -1));
		directed.push_back(mk(0, -one, one, 0, 0, 0, 0, -one));
		foreach (directed[i])
			send_cell(directed[i]);
		drain();

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: ;
				1: set_spacing(31'(one), 31'(one), 31'(one), 31'hFFFF);
				2: set_spacing(31'd1, 31'd1, 31'd1, 31'd0);
				3: set_spacing(31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'hFFFF);
				4: set_spacing(31'd0, 31'(one), 31'd0, 31'($urandom));
				5: set_spacing(31'($urandom_range(1 << 16, 1 << 23)),
					31'($urandom_range(1 << 16, 1 << 23)),
					31'($urandom_range(1 << 16, 1 << 23)), 31'($urandom));
				6: set_spacing(31'($urandom), 31'($urandom), 31'($urandom), 31'($urandom));
				default: set_spacing(31'($urandom_range(1, 1 << 21)),
					31'($urandom_range(1 << 19, 1 << 21)),
					31'($urandom_range(1 << 18, 1 << 20)), 31'($urandom));
			endcase
			case (p % 4)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 66; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 66; end
				default: begin send_idle_pct = 24; stall_pct = 24; end
			endcase
			for (int i = 0; i < ITEMS_PER_PHASE; i++)
				send_cell(rand_cell());
			drain();
		end

		if (sb.errors == 0)
			$display("level_set_reinit_cell_update_top: match");
		else
			$display("level_set_reinit_cell_update_top: mismatch");
		$finish;
	end
endmodule

// ===== level_set_reinit_cell_update_top.f =====
rtl/core/lsr_pkg.sv
rtl/core/lsr_delay.sv
rtl/core/lsr_isqrt.sv
rtl/core/lsr_div.sv
rtl/core/level_set_reinit_cell_update_top.sv
rtl/core/lsr_chk.sv
tb/tb.sv
